[rtl/afrm_pkg.sv]
// Package for the audio fragment ring manager: codes, flag bits, result and
// bookkeeping types shared by the controller, the datapath and the top level.
// Depends on nothing.
package afrm_pkg;

  localparam int DEF_MAX_DMA_FRAGMENTS = 16;
  localparam int DEF_MAX_EXTRA_BUFFERS = 16;
  localparam int NRES = 3;

  typedef enum logic [2:0] {
    ACT_OPEN = 3'd0, ACT_CLOSE = 3'd1, ACT_REQUEST = 3'd2, ACT_INTR = 3'd3, ACT_POLL = 3'd4
  } action_t;

  localparam logic [2:0] RPL_NONE = 3'd0, RPL_OK = 3'd1, RPL_SUSPEND = 3'd2,
                         RPL_BAD_COUNT = 3'd3, RPL_BUSY = 3'd4, RPL_REVIVE = 3'd5,
                         RPL_NO_STATUS = 3'd6;
  localparam logic [2:0] CPY_NONE = 3'd0, CPY_USER_DMA = 3'd1, CPY_USER_EXTRA = 3'd2,
                         CPY_EXTRA_DMA = 3'd3, CPY_DMA_EXTRA = 3'd4,
                         CPY_EXTRA_USER = 3'd5, CPY_DMA_USER = 3'd6;
  localparam logic [2:0] DEV_NONE = 3'd0, DEV_START = 3'd1, DEV_PAUSE = 3'd2,
                         DEV_RESUME = 3'd3, DEV_STOP = 3'd4;

  localparam logic [1:0] REG_DIRECTION = 2'd0, REG_DMA_FRAGMENTS = 2'd1,
                         REG_EXTRA_BUFFERS = 2'd2, REG_FRAGMENT_BYTES = 2'd3;

  // flag bit positions
  localparam int FB_OPENED = 0, FB_BUSY = 1, FB_PENDING = 2, FB_READY = 3, FB_OOD = 4;

  // field-use bits of one result
  localparam logic [2:0] U_REPLY = 3'd1, U_COPY = 3'd2, U_CMD = 3'd4;

  typedef struct packed {
    logic [2:0]  reply_code;
    logic [2:0]  copy_kind;
    logic [3:0]  source_index;
    logic [3:0]  dest_index;
    logic [2:0]  device_command;
    logic [15:0] revive_status;
    logic        last;
  } result_t;

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_EMIT} ctrl_state_t;

  typedef struct packed {
    logic       load;
    logic       exec;
    logic [1:0] sel;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] nres;
  } dp_status_t;

endpackage

[rtl/afrm_if.sv]
// Handshake channels of the fragment ring manager: event beats in, result
// beats out. Depends on nothing.
interface afrm_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [15:0] request_count;
  modport source (output valid, action, request_count, input ready);
  modport sink (input valid, action, request_count, output ready);
endinterface

interface afrm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reply_code;
  logic [2:0]  copy_kind;
  logic [3:0]  source_index;
  logic [3:0]  dest_index;
  logic [2:0]  device_command;
  logic [15:0] revive_status;
  logic        last;
  modport source (output valid, reply_code, copy_kind, source_index, dest_index,
                  device_command, revive_status, last, input ready);
  modport sink (input valid, reply_code, copy_kind, source_index, dest_index,
                device_command, revive_status, last, output ready);
endinterface

[rtl/afrm_ctrl.sv]
// Controller of the fragment ring manager: accept, evaluate, emit sequence.
// Depends on afrm_pkg.
module afrm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output afrm_pkg::dp_cmd_t    cmd,
  input  afrm_pkg::dp_status_t status
);
  import afrm_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic [1:0]  sel_r, sel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sel_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd.load  = 1'b0;
    cmd.exec  = 1'b0;
    cmd.sel   = sel_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        sel_nxt   = 2'd0;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          // status.nres counts results; the final one carries last
          if (sel_r == status.nres - 2'd1) state_nxt = ST_IDLE;
          else sel_nxt = sel_r + 2'd1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

[rtl/afrm_dp.sv]
// Datapath of the fragment ring manager: registers, ring state, event
// evaluation into a three-entry result buffer. Depends on afrm_pkg.
module afrm_dp #(
  parameter int MAX_DMA_FRAGMENTS = afrm_pkg::DEF_MAX_DMA_FRAGMENTS,
  parameter int MAX_EXTRA_BUFFERS = afrm_pkg::DEF_MAX_EXTRA_BUFFERS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic [2:0]           in_action,
  input  logic [15:0]          in_request_count,
  input  afrm_pkg::dp_cmd_t    cmd,
  output afrm_pkg::dp_status_t status,
  output afrm_pkg::result_t    result
);
  import afrm_pkg::*;

  typedef struct packed {
    logic [4:0]  dri, dfi, dc, eri, efi, ec;
    logic [4:0]  fl;
    logic        md;
    logic [15:0] rv;
  } st_t;

  typedef struct packed {
    logic [1:0]            n;
    logic [2:0][2:0]       used;
    result_t [NRES-1:0]    r;
  } buf_t;

  typedef struct packed {
    st_t  s;
    buf_t b;
  } wk_t;

  logic        direction_r;
  logic [4:0]  dma_fragments_r, extra_buffers_r;
  logic [15:0] fragment_bytes_r;
  logic [2:0]  action_r;
  logic [15:0] count_r;
  st_t         st_r, st_nxt;
  buf_t        buf_r, buf_nxt;

  function automatic logic [4:0] adv(logic [4:0] i, logic [4:0] n);
    logic [5:0] p;
    p = {1'b0, i} + 6'd1;
    return (p >= {1'b0, n}) ? 5'd0 : p[4:0];
  endfunction
  function automatic logic [4:0] inc(logic [4:0] c);
    return (c < 5'd31) ? c + 5'd1 : c;
  endfunction
  function automatic logic [4:0] dec(logic [4:0] c);
    return (c > 5'd0) ? c - 5'd1 : 5'd0;
  endfunction
  function automatic logic [4:0] ring_size(logic [4:0] v, int mx);
    if (v == 5'd0) return 5'd1;
    if (int'(v) > mx) return 5'(mx);
    return v;
  endfunction

  // opens a new result, if room remains, when the field is taken or none exists yet
  function automatic buf_t open_slot(buf_t b, logic [2:0] f);
    if (b.n == 2'd0 || (b.used[b.n - 2'd1] & f) != 3'd0) begin
      if (b.n < 2'(NRES)) begin
        b.r[b.n]    = '0;
        b.used[b.n] = 3'd0;
        b.n         = b.n + 2'd1;
      end
    end
    b.used[b.n - 2'd1] = b.used[b.n - 2'd1] | f;
    return b;
  endfunction

  function automatic wk_t put_reply(wk_t w, logic [2:0] code, logic [15:0] stat);
    w.b = open_slot(w.b, U_REPLY);
    w.b.r[w.b.n - 2'd1].reply_code    = code;
    w.b.r[w.b.n - 2'd1].revive_status = stat;
    return w;
  endfunction
  function automatic wk_t put_copy(wk_t w, logic [2:0] k, logic [4:0] s, logic [4:0] d);
    w.b = open_slot(w.b, U_COPY);
    w.b.r[w.b.n - 2'd1].copy_kind    = k;
    w.b.r[w.b.n - 2'd1].source_index = s[3:0];
    w.b.r[w.b.n - 2'd1].dest_index   = d[3:0];
    return w;
  endfunction
  function automatic wk_t put_cmd(wk_t w, logic [2:0] c);
    w.b = open_slot(w.b, U_CMD);
    w.b.r[w.b.n - 2'd1].device_command = c;
    return w;
  endfunction

  function automatic wk_t from_user(wk_t w, logic [4:0] d, logic [4:0] e, logic [15:0] fb);
    if (w.s.dc >= d && w.s.ec >= e) return w;
    if (!w.s.fl[FB_PENDING] || w.s.fl[FB_READY]) return w;
    if (w.s.dc < d) begin
      w = put_copy(w, CPY_USER_DMA, 5'd0, w.s.dfi);
      w.s.dc  = inc(w.s.dc);
      w.s.dfi = adv(w.s.dfi, d);
    end else begin
      w = put_copy(w, CPY_USER_EXTRA, 5'd0, w.s.efi);
      w.s.ec  = inc(w.s.ec);
      w.s.efi = adv(w.s.efi, e);
    end
    if (w.s.fl[FB_OOD]) begin
      w.s.fl[FB_OOD] = 1'b0;
      w = put_cmd(w, DEV_RESUME);
    end
    w.s.rv = fb;
    w.s.fl[FB_READY] = 1'b1;
    return w;
  endfunction

  function automatic wk_t to_user(wk_t w, logic [4:0] d, logic [4:0] e, logic [15:0] fb);
    if (!w.s.fl[FB_PENDING] || w.s.fl[FB_READY]) return w;
    if (w.s.ec == 5'd0 && w.s.dc == 5'd0) return w;
    if (w.s.ec != 5'd0) begin
      w = put_copy(w, CPY_EXTRA_USER, w.s.eri, 5'd0);
      w.s.eri = adv(w.s.eri, e);
      w.s.ec  = dec(w.s.ec);
    end else begin
      w = put_copy(w, CPY_DMA_USER, w.s.dri, 5'd0);
      w.s.dri = adv(w.s.dri, d);
      w.s.dc  = dec(w.s.dc);
    end
    w.s.rv = fb;
    w.s.fl[FB_READY] = 1'b1;
    return w;
  endfunction

  function automatic wk_t do_close(wk_t w);
    if (!w.s.md && !w.s.fl[FB_OOD]) begin
      w.s.fl[FB_OPENED] = 1'b0;
      return w;
    end
    w.s.fl[FB_OPENED] = 1'b0;
    w.s.fl[FB_BUSY]   = 1'b0;
    w = put_cmd(w, DEV_STOP);
    return w;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r      <= 1'b0;
      dma_fragments_r  <= 5'd2;
      extra_buffers_r  <= 5'd4;
      fragment_bytes_r <= 16'd4096;
      st_r             <= '{fl: 5'b10000, default: '0};
      buf_r            <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DIRECTION:      direction_r      <= cfg_data[0];
          REG_DMA_FRAGMENTS:  dma_fragments_r  <= cfg_data[4:0];
          REG_EXTRA_BUFFERS:  extra_buffers_r  <= cfg_data[4:0];
          REG_FRAGMENT_BYTES: fragment_bytes_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.exec) begin
        st_r  <= st_nxt;
        buf_r <= buf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_action;
      count_r  <= in_request_count;
    end
  end

  always_comb begin
    wk_t        w;
    logic [4:0] d, e;
    d = ring_size(dma_fragments_r, MAX_DMA_FRAGMENTS);
    e = ring_size(extra_buffers_r, MAX_EXTRA_BUFFERS);
    w.s = st_r;
    w.b = '0;
    case (action_r)
      ACT_OPEN: begin
        if (w.s.fl[FB_OPENED] || w.s.fl[FB_BUSY]) begin
          w = put_reply(w, RPL_BUSY, 16'd0);
        end else begin
          w.s.fl[FB_OPENED]  = 1'b1;
          w.s.fl[FB_OOD]     = 1'b1;
          w.s.fl[FB_PENDING] = 1'b0;
          w.s.dri = '0; w.s.dfi = '0; w.s.dc = '0;
          w.s.eri = '0; w.s.efi = '0; w.s.ec = '0;
          w.s.md  = direction_r;
          w = put_reply(w, RPL_OK, 16'd0);
        end
      end
      ACT_CLOSE: begin
        w = put_reply(w, RPL_OK, 16'd0);
        w = do_close(w);
      end
      ACT_REQUEST: begin
        if (count_r != fragment_bytes_r) begin
          w = put_reply(w, RPL_BAD_COUNT, 16'd0);
        end else if (w.s.fl[FB_BUSY] && w.s.md != direction_r) begin
          w = put_reply(w, RPL_BUSY, 16'd0);
        end else begin
          w = put_reply(w, RPL_SUSPEND, 16'd0);
          w.s.fl[FB_PENDING] = 1'b1;
          if (!direction_r) begin
            w = from_user(w, d, e, fragment_bytes_r);
            if (!w.s.fl[FB_BUSY]) begin
              w = put_cmd(w, DEV_START);
              w.s.fl[FB_BUSY] = 1'b1;
              w.s.dri = '0;
              w.s.md  = 1'b0;
            end
          end else if (!w.s.fl[FB_BUSY]) begin
            w = put_cmd(w, DEV_START);
            w.s.fl[FB_BUSY] = 1'b1;
            w.s.dri = '0;
            w.s.md  = 1'b1;
          end else begin
            w = to_user(w, d, e, fragment_bytes_r);
          end
        end
      end
      ACT_INTR: begin
        if (w.s.fl[FB_BUSY] && !w.s.md) begin
          w.s.dri = adv(w.s.dri, d);
          w.s.dc  = dec(w.s.dc);
          if (w.s.ec != 5'd0) begin
            w = put_copy(w, CPY_EXTRA_DMA, w.s.eri, w.s.dfi);
            w.s.eri = adv(w.s.eri, e);
            w.s.dfi = adv(w.s.dfi, d);
            w.s.ec  = dec(w.s.ec);
            w.s.dc  = inc(w.s.dc);
          end
          w = from_user(w, d, e, fragment_bytes_r);
          if (w.s.dc == 5'd0) begin
            w.s.fl[FB_OOD] = 1'b1;
            if (!w.s.fl[FB_OPENED]) w = do_close(w);
            else w = put_cmd(w, DEV_PAUSE);
          end
        end else if (w.s.fl[FB_BUSY]) begin
          w.s.dc  = inc(w.s.dc);
          w.s.dfi = adv(w.s.dfi, d);
          w = to_user(w, d, e, fragment_bytes_r);
          if (w.s.dc >= d) begin
            if (w.s.ec >= e) begin
              // both rings full: overflow
              w = put_cmd(w, DEV_STOP);
              w.s.fl[FB_BUSY]  = 1'b0;
              w.s.rv           = 16'd0;
              w.s.fl[FB_READY] = 1'b1;
            end else begin
              w = put_copy(w, CPY_DMA_EXTRA, w.s.dri, w.s.efi);
              w.s.dc  = dec(w.s.dc);
              w.s.ec  = inc(w.s.ec);
              w.s.dri = adv(w.s.dri, d);
              w.s.efi = adv(w.s.efi, e);
            end
          end
        end
      end
      ACT_POLL: begin
        if (w.s.fl[FB_READY]) begin
          w = put_reply(w, RPL_REVIVE, w.s.rv);
          w.s.fl[FB_READY]   = 1'b0;
          w.s.fl[FB_PENDING] = 1'b0;
        end else begin
          w = put_reply(w, RPL_NO_STATUS, 16'd0);
        end
      end
      default: ;
    endcase
    if (w.b.n == 2'd0) w.b = open_slot(w.b, 3'd0);
    w.b.r[w.b.n - 2'd1].last = 1'b1;
    st_nxt  = w.s;
    buf_nxt = w.b;
  end

  assign status.nres = buf_r.n;
  assign result      = buf_r.r[cmd.sel];
endmodule

[rtl/audio_fragment_ring_manager_core.sv]
// Audio fragment ring manager, top level.
// An event beat is taken in the idle state and evaluated in the cycle after; its
// one to three result beats follow one per cycle from the result buffer while out_ready is high.
// A new event beat is taken only once the last result beat of the one before has gone.
// Reset (synchronous, rst_n low): rings empty, flags clear but out-of-data,
// registers at direction 0, 2 DMA fragments, 4 extra buffers, 4096 bytes.
module audio_fragment_ring_manager_core #(
  parameter int MAX_DMA_FRAGMENTS = afrm_pkg::DEF_MAX_DMA_FRAGMENTS,
  parameter int MAX_EXTRA_BUFFERS = afrm_pkg::DEF_MAX_EXTRA_BUFFERS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  afrm_in_if.sink     in_ch,
  afrm_out_if.source  out_ch
);
  import afrm_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  result_t    result;

  afrm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .status    (status)
  );

  afrm_dp #(
    .MAX_DMA_FRAGMENTS (MAX_DMA_FRAGMENTS),
    .MAX_EXTRA_BUFFERS (MAX_EXTRA_BUFFERS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_action        (in_ch.action),
    .in_request_count (in_ch.request_count),
    .cmd              (cmd),
    .status           (status),
    .result           (result)
  );

  assign out_ch.reply_code     = result.reply_code;
  assign out_ch.copy_kind      = result.copy_kind;
  assign out_ch.source_index   = result.source_index;
  assign out_ch.dest_index     = result.dest_index;
  assign out_ch.device_command = result.device_command;
  assign out_ch.revive_status  = result.revive_status;
  assign out_ch.last           = result.last;
endmodule

[tb/tb.sv]
// Testbench for audio_fragment_ring_manager_core: runs directed and random event
// beats through the block and checks each result beat against a local predictor.
// Depends on afrm_pkg, afrm_if and the core RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import afrm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_SHOWN = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  afrm_in_if in_ch();
  afrm_out_if out_ch();

  audio_fragment_ring_manager_core uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
  );

  always #1 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = ACT_OPEN;
    in_ch.request_count = '0;
    out_ch.ready = 1'b0;
  end

  // shadow copy of the block's registers and bookkeeping
  logic        sh_dir = 1'b0;
  logic [4:0]  sh_dma_frags = 5'd2;
  logic [4:0]  sh_extra_bufs = 5'd4;
  logic [15:0] sh_frag_bytes = 16'd4096;
  logic [3:0]  dma_rd = '0, dma_wr = '0, ext_rd = '0, ext_wr = '0;
  logic [4:0]  dma_cnt = '0, ext_cnt = '0;
  logic f_opened = 0, f_busy = 0, f_pending = 0, f_ready = 0, f_ood = 1;
  logic        latched_mode = 1'b0;
  logic [15:0] revive_val = '0;

  result_t beat_buf [NRES];
  logic [2:0] beat_used [NRES];
  int beat_cnt;

  result_t expected_beats [$];
  int mismatches = 0;
  int cycles = 0;
  int tx_idle_pct = 0, rx_idle_pct = 0;
  int rx_hold_left = 0;
  bit rx_hold_req = 0;
  result_t got, want;

  function automatic int ring_len(logic [4:0] v, int mx);
    if (v == 0) return 1;
    if (v > mx) return mx;
    return v;
  endfunction

  function automatic logic [3:0] step_idx(logic [3:0] idx, int n);
    return (int'(idx) + 1 >= n) ? 4'd0 : idx + 4'd1;
  endfunction

  function automatic logic [4:0] cnt_up(logic [4:0] c);
    return (c < 31) ? c + 5'd1 : c;
  endfunction

  function automatic logic [4:0] cnt_down(logic [4:0] c);
    return (c > 0) ? c - 5'd1 : 5'd0;
  endfunction

  // a field already used in the current beat opens a new one
  function automatic int beat_slot(logic [2:0] f);
    if (beat_cnt == 0 || (beat_used[beat_cnt-1] & f) != 0) begin
      if (beat_cnt < NRES) begin
        beat_buf[beat_cnt] = '0;
        beat_used[beat_cnt] = '0;
        beat_cnt++;
      end
    end
    beat_used[beat_cnt-1] |= f;
    return beat_cnt - 1;
  endfunction

  task automatic put_reply(logic [2:0] code, logic [15:0] status);
    int k;
    k = beat_slot(U_REPLY);
    beat_buf[k].reply_code = code;
    beat_buf[k].revive_status = status;
  endtask

  task automatic put_copy(logic [2:0] kind, logic [3:0] src, logic [3:0] dst);
    int k;
    k = beat_slot(U_COPY);
    beat_buf[k].copy_kind = kind;
    beat_buf[k].source_index = src;
    beat_buf[k].dest_index = dst;
  endtask

  task automatic put_cmd(logic [2:0] c);
    int k;
    k = beat_slot(U_CMD);
    beat_buf[k].device_command = c;
  endtask

  task automatic fill_from_user(int d, int e);
    if (dma_cnt >= d && ext_cnt >= e) return;
    if (!f_pending || f_ready) return;
    if (dma_cnt < d) begin
      put_copy(CPY_USER_DMA, 4'd0, dma_wr);
      dma_cnt = cnt_up(dma_cnt);
      dma_wr = step_idx(dma_wr, d);
    end else begin
      put_copy(CPY_USER_EXTRA, 4'd0, ext_wr);
      ext_cnt = cnt_up(ext_cnt);
      ext_wr = step_idx(ext_wr, e);
    end
    if (f_ood) begin
      f_ood = 0;
      put_cmd(DEV_RESUME);
    end
    revive_val = sh_frag_bytes;
    f_ready = 1;
  endtask

  task automatic drain_to_user(int d, int e);
    if (!f_pending || f_ready) return;
    if (ext_cnt == 0 && dma_cnt == 0) return;
    if (ext_cnt != 0) begin
      put_copy(CPY_EXTRA_USER, ext_rd, 4'd0);
      ext_rd = step_idx(ext_rd, e);
      ext_cnt = cnt_down(ext_cnt);
    end else begin
      put_copy(CPY_DMA_USER, dma_rd, 4'd0);
      dma_rd = step_idx(dma_rd, d);
      dma_cnt = cnt_down(dma_cnt);
    end
    revive_val = sh_frag_bytes;
    f_ready = 1;
  endtask

  task automatic close_device();
    if (latched_mode == 0 && !f_ood) begin
      f_opened = 0;
      return;
    end
    f_opened = 0;
    f_busy = 0;
    put_cmd(DEV_STOP);
  endtask

  task automatic predict_event(logic [2:0] act, logic [15:0] count);
    int d, e;
    d = ring_len(sh_dma_frags, DEF_MAX_DMA_FRAGMENTS);
    e = ring_len(sh_extra_bufs, DEF_MAX_EXTRA_BUFFERS);
    beat_cnt = 0;
    case (act)
      ACT_OPEN: begin
        if (f_opened || f_busy) put_reply(RPL_BUSY, 0);
        else begin
          f_opened = 1; f_ood = 1; f_pending = 0;
          dma_rd = 0; dma_wr = 0; dma_cnt = 0;
          ext_rd = 0; ext_wr = 0; ext_cnt = 0;
          latched_mode = sh_dir;
          put_reply(RPL_OK, 0);
        end
      end
      ACT_CLOSE: begin
        put_reply(RPL_OK, 0);
        close_device();
      end
      ACT_REQUEST: begin
        if (count != sh_frag_bytes) put_reply(RPL_BAD_COUNT, 0);
        else if (f_busy && latched_mode != sh_dir) put_reply(RPL_BUSY, 0);
        else begin
          put_reply(RPL_SUSPEND, 0);
          f_pending = 1;
          if (sh_dir == 0) begin
            fill_from_user(d, e);
            if (!f_busy) begin
              put_cmd(DEV_START);
              f_busy = 1; dma_rd = 0; latched_mode = 0;
            end
          end else if (!f_busy) begin
            put_cmd(DEV_START);
            f_busy = 1; dma_rd = 0; latched_mode = 1;
          end else drain_to_user(d, e);
        end
      end
      ACT_INTR: begin
        if (f_busy && latched_mode == 0) begin
          dma_rd = step_idx(dma_rd, d);
          dma_cnt = cnt_down(dma_cnt);
          if (ext_cnt != 0) begin
            put_copy(CPY_EXTRA_DMA, ext_rd, dma_wr);
            ext_rd = step_idx(ext_rd, e);
            dma_wr = step_idx(dma_wr, d);
            ext_cnt = cnt_down(ext_cnt);
            dma_cnt = cnt_up(dma_cnt);
          end
          fill_from_user(d, e);
          if (dma_cnt == 0) begin
            f_ood = 1;
            if (!f_opened) close_device();
            else put_cmd(DEV_PAUSE);
          end
        end else if (f_busy) begin
          dma_cnt = cnt_up(dma_cnt);
          dma_wr = step_idx(dma_wr, d);
          drain_to_user(d, e);
          if (dma_cnt >= d) begin
            if (ext_cnt >= e) begin
              // both rings full: record overflow
              put_cmd(DEV_STOP);
              f_busy = 0;
              revive_val = 0;
              f_ready = 1;
            end else begin
              put_copy(CPY_DMA_EXTRA, dma_rd, ext_wr);
              dma_cnt = cnt_down(dma_cnt);
              ext_cnt = cnt_up(ext_cnt);
              dma_rd = step_idx(dma_rd, d);
              ext_wr = step_idx(ext_wr, e);
            end
          end
        end
      end
      ACT_POLL: begin
        if (f_ready) begin
          put_reply(RPL_REVIVE, revive_val);
          f_ready = 0; f_pending = 0;
        end else put_reply(RPL_NO_STATUS, 0);
      end
      default: ;
    endcase
    if (beat_cnt == 0) void'(beat_slot(3'd0));
    beat_buf[beat_cnt-1].last = 1'b1;
    for (int k = 0; k < beat_cnt; k++) expected_beats.push_back(beat_buf[k]);
  endtask

  // result side: ready pattern and long holds
  always @(posedge clk) begin
    if (rx_hold_req) begin
      rx_hold_req = 0;
      rx_hold_left = 80;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // valid and ready settle well before the falling edge
  always @(negedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.reply_code = out_ch.reply_code;
      got.copy_kind = out_ch.copy_kind;
      got.source_index = out_ch.source_index;
      got.dest_index = out_ch.dest_index;
      got.device_command = out_ch.device_command;
      got.revive_status = out_ch.revive_status;
      got.last = out_ch.last;
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) $display("unexpected result beat %p", got);
      end else begin
        want = expected_beats.pop_front();
        if (got.reply_code !== want.reply_code || got.copy_kind !== want.copy_kind ||
            got.source_index !== want.source_index || got.dest_index !== want.dest_index ||
            got.device_command !== want.device_command ||
            got.revive_status !== want.revive_status || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("result mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // called right after a rising edge; returns right after the accepting edge
  task automatic send_event(logic [2:0] act, logic [15:0] count);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.request_count <= count;
    forever begin
      @(negedge clk);
      if (in_ch.ready) break;
      @(posedge clk);
    end
    @(posedge clk);
    predict_event(act, count);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // write enable stays high across back-to-back writes; setup drops it
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_DIRECTION: sh_dir = val[0];
      REG_DMA_FRAGMENTS: sh_dma_frags = val[4:0];
      REG_EXTRA_BUFFERS: sh_extra_bufs = val[4:0];
      default: sh_frag_bytes = val;
    endcase
  endtask

  task automatic setup(logic dir, logic [4:0] d, logic [4:0] e, logic [15:0] fb);
    wait_idle();
    write_reg(REG_DIRECTION, {15'd0, dir});
    write_reg(REG_DMA_FRAGMENTS, {11'd0, d});
    write_reg(REG_EXTRA_BUFFERS, {11'd0, e});
    write_reg(REG_FRAGMENT_BYTES, fb);
    cfg_we <= 1'b0;
  endtask

  task automatic test_playback_directed();
    send_event(ACT_POLL, 16'd0);
    send_event(ACT_INTR, 16'd0);
    send_event(ACT_OPEN, 16'd0);
    send_event(ACT_OPEN, 16'd0);
    send_event(ACT_REQUEST, 16'd0);
    send_event(ACT_REQUEST, 16'hFFFF);
    for (int i = 0; i < 4; i++) begin
      send_event(ACT_REQUEST, sh_frag_bytes);
      send_event(ACT_POLL, 16'd0);
    end
    send_event(ACT_INTR, 16'd0);
    send_event(ACT_CLOSE, 16'd0);
    repeat (4) send_event(ACT_INTR, 16'd0);
    send_event(3'd7, 16'hA5A5);
    send_event(3'd5, 16'h5A5A);
  endtask

  task automatic test_record_directed();
    setup(1'b1, 5'd1, 5'd1, 16'hFFFF);
    send_event(ACT_OPEN, 16'd0);
    send_event(ACT_REQUEST, 16'hFFFF);
    repeat (3) send_event(ACT_INTR, 16'd0);
    send_event(ACT_POLL, 16'd0);
    send_event(ACT_REQUEST, 16'hFFFF);
    send_event(ACT_POLL, 16'd0);
    send_event(ACT_CLOSE, 16'd0);
  endtask

  task automatic random_events(int n);
    int r;
    logic [15:0] cnt;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      cnt = ($urandom_range(9) == 0) ? 16'($urandom) : sh_frag_bytes;
      if (r < 6) send_event(ACT_OPEN, 16'($urandom));
      else if (r < 11) send_event(ACT_CLOSE, 16'($urandom));
      else if (r < 42) send_event(ACT_REQUEST, cnt);
      else if (r < 72) send_event(ACT_INTR, 16'($urandom));
      else if (r < 96) send_event(ACT_POLL, 16'($urandom));
      else send_event(3'($urandom_range(7, 5)), 16'($urandom));
    end
  endtask

  task automatic test_random_phase(logic dir, logic [4:0] d, logic [4:0] e, logic [15:0] fb);
    setup(dir, d, e, fb);
    send_event(ACT_CLOSE, 16'd0);
    send_event(ACT_OPEN, 16'd0);
    random_events(24);
  endtask

  task automatic test_backpressure();
    setup(1'b0, 5'd3, 5'd2, 16'd512);
    rx_hold_req = 1;
    send_event(ACT_CLOSE, 16'd0);
    send_event(ACT_OPEN, 16'd0);
    random_events(12);
    // sender waits for the block to drain fully
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    random_events(8);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tx_idle_pct = 14; rx_idle_pct = 75;
    test_playback_directed();
    test_record_directed();
    test_random_phase(1'b0, 5'd2, 5'd4, 16'd4096);
    test_random_phase(1'b1, 5'd16, 5'd16, 16'd1);
    tx_idle_pct = 75; rx_idle_pct = 14;
    test_random_phase(1'b0, 5'd0, 5'd31, 16'd100);
    test_random_phase(1'b1, 5'd31, 5'd0, 16'd7);
    tx_idle_pct = 0; rx_idle_pct = 0;
    test_random_phase(1'b0, 5'd16, 5'd1, 16'hFFFF);
    test_random_phase(1'b1, 5'd3, 5'd2, 16'd2048);
    test_backpressure();
    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/afrm_pkg.sv
rtl/afrm_if.sv
rtl/afrm_ctrl.sv
rtl/afrm_dp.sv
rtl/audio_fragment_ring_manager_core.sv
tb/tb.sv
